@@ hw/rtl/hdbn_pkg.sv @@
// hdbn_pkg: shared types, constants and helper functions for the HDBn line encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package hdbn_pkg;

    // Largest HDB order supported; runs of MAX_ORDER+1 zeros are the longest replaced.
    localparam int MAX_ORDER   = 7;
    localparam int DELAY_DEPTH = MAX_ORDER + 1;
    localparam int IDX_W       = $clog2(DELAY_DEPTH);
    localparam int CNT_W       = $clog2(MAX_ORDER + 1);

    // Configuration register file
    localparam int CFG_W    = 3;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;
    localparam logic [CFG_W-1:0] ORDER_RESET = 3'd3;

    typedef enum logic [0:0] {
        REG_ZERO_RUN_ORDER = 1'b0
    } t_reg_idx;

    typedef logic signed [1:0] t_symbol;

    localparam t_symbol SYM_ZERO = 2'sb00;
    localparam t_symbol SYM_POS  = 2'sb01;
    localparam t_symbol SYM_NEG  = 2'sb11;

    // Result handed from the encoder core to the output stage
    typedef struct packed {
        t_symbol symbol;
    } t_enc_result;

    function automatic t_symbol pol_symbol(input logic positive);
        pol_symbol = positive ? SYM_POS : SYM_NEG;
    endfunction

    // Register value 0 acts as order 1; values above MAX_ORDER saturate.
    function automatic logic [IDX_W-1:0] effective_order(input logic [CFG_W-1:0] order);
        logic [IDX_W-1:0] n;
        if (order == '0) begin
            n = IDX_W'(1);
        end else if (32'(order) > MAX_ORDER) begin
            n = IDX_W'(MAX_ORDER);
        end else begin
            n = IDX_W'(order);
        end
        effective_order = n;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hdbn_cfg_regs.sv @@
// hdbn_cfg_regs: APB-style configuration register (zero_run_order).
// Depends on hdbn_pkg.
`default_nettype none

module hdbn_cfg_regs
    import hdbn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [CFG_W-1:0]  o_order
);

    logic [CFG_W-1:0] r_order;
    logic             reg_hit;

    // Registers sit at byte address 4*i
    assign reg_hit = (t_reg_idx'(paddr[APB_AW-1]) == REG_ZERO_RUN_ORDER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_order <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata = APB_DW'(r_order);
        end
    end

    assign pready  = 1'b1;
    assign o_order = r_order;

endmodule

`default_nettype wire

@@ hw/rtl/hdbn_enc_core.sv @@
// hdbn_enc_core: AMI marking, zero-run substitution (000V / B00V) and symbol delay line.
// Depends on hdbn_pkg.
`default_nettype none

module hdbn_enc_core
    import hdbn_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic             i_data_bit,
    input  wire logic [CFG_W-1:0] i_order,
    output t_enc_result           o_result
);

    t_symbol          r_line [DELAY_DEPTH];
    t_symbol          n_line [DELAY_DEPTH];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_next_pos, n_next_pos;
    logic             r_last_pos, n_last_pos;
    logic             r_odd, n_odd;

    logic [IDX_W-1:0] n_ord;
    logic [CNT_W:0]   cnt_inc;
    logic             substitute;
    logic             balance;
    logic             last_after;
    t_symbol          sym;

    assign n_ord      = effective_order(i_order);
    assign cnt_inc    = {1'b0, r_cnt} + 1'b1;
    assign substitute = !i_data_bit && (n_ord > IDX_W'(1))
                        && (cnt_inc >= ((CNT_W+1)'(n_ord) + 1'b1));
    // Even number of marks since last violation: balancing pulse needed
    assign balance    = substitute && !r_odd;
    assign last_after = balance ? !r_last_pos : r_last_pos;

    always_comb begin
        n_cnt      = r_cnt;
        n_next_pos = r_next_pos;
        n_last_pos = r_last_pos;
        n_odd      = r_odd;
        sym        = SYM_ZERO;
        if (i_data_bit) begin
            sym        = pol_symbol(r_next_pos);
            n_last_pos = r_next_pos;
            n_next_pos = !r_next_pos;
            n_odd      = !r_odd;
            n_cnt      = '0;
        end else if (n_ord > IDX_W'(1)) begin
            if (substitute) begin
                sym        = pol_symbol(last_after);
                n_last_pos = last_after;
                n_next_pos = !last_after;
                n_odd      = 1'b0;
                n_cnt      = '0;
            end else begin
                n_cnt = cnt_inc[CNT_W-1:0];
            end
        end else begin
            n_cnt = '0;
        end
    end

    // Shift by one; B lands on the first zero of the run, which moves into slot n.
    always_comb begin
        n_line[0] = sym;
        for (int k = 1; k < DELAY_DEPTH; k++) begin
            if (balance && (IDX_W'(k) == n_ord)) begin
                n_line[k] = pol_symbol(last_after);
            end else begin
                n_line[k] = r_line[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DELAY_DEPTH; k++) begin
                r_line[k] <= SYM_ZERO;
            end
            r_cnt      <= '0;
            r_next_pos <= 1'b1;
            r_last_pos <= 1'b1;
            r_odd      <= 1'b1;
        end else if (i_advance) begin
            r_line     <= n_line;
            r_cnt      <= n_cnt;
            r_next_pos <= n_next_pos;
            r_last_pos <= n_last_pos;
            r_odd      <= n_odd;
        end
    end

    assign o_result.symbol = r_line[n_ord];

endmodule

`default_nettype wire

@@ hw/rtl/hdbn_out_stage.sv @@
// hdbn_out_stage: result register with valid/stall handshake and rail decode.
// Depends on hdbn_pkg.
`default_nettype none

module hdbn_out_stage
    import hdbn_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire t_enc_result i_result,
    input  wire logic        i_out_stall,
    output logic             o_full_blocked,
    output logic             o_out_valid,
    output t_symbol          o_line_symbol,
    output logic             o_pos_rail,
    output logic             o_neg_rail
);

    logic    r_valid;
    t_symbol r_symbol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_symbol <= i_result.symbol;
        end
    end

    // Only a held, unaccepted result blocks a new request
    assign o_full_blocked = r_valid && i_out_stall;
    assign o_out_valid    = r_valid;
    assign o_line_symbol  = r_symbol;
    assign o_pos_rail     = (r_symbol == SYM_POS);
    assign o_neg_rail     = (r_symbol == SYM_NEG);

endmodule

`default_nettype wire

@@ hw/rtl/hdbn_line_encoder.sv @@
// HDBn line encoder (HDB3 at the default order 3): one data bit in, one ternary
// line symbol out per request, AMI marking with 000V/B00V substitution of runs of
// order+1 zeros; order 1 (or 0) gives plain AMI. One request is taken every clock
// cycle; the result appears in the output register in the cycle after acceptance and
// a new request is taken while it waits, stalling only when that register is held.
// Each result carries the line symbol decided order+1 requests earlier (the first
// order+1 results are zero symbols). Changing zero_run_order moves the delay tap
// at once, without flushing. No clearing pass after reset.
// Depends on hdbn_pkg, hdbn_cfg_regs, hdbn_enc_core, hdbn_out_stage.
`default_nettype none

module hdbn_line_encoder
    import hdbn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_data_bit,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_symbol                o_line_symbol,
    output logic                   o_pos_rail,
    output logic                   o_neg_rail,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    logic [CFG_W-1:0] order;
    logic             accept;
    logic             blocked;
    t_enc_result      result;

    assign o_in_stall = blocked;
    assign accept     = i_in_valid && !blocked;

    hdbn_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_order (order)
    );

    hdbn_enc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (accept),
        .i_data_bit (i_data_bit),
        .i_order    (order),
        .o_result   (result)
    );

    hdbn_out_stage u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_result       (result),
        .i_out_stall    (i_out_stall),
        .o_full_blocked (blocked),
        .o_out_valid    (o_out_valid),
        .o_line_symbol  (o_line_symbol),
        .o_pos_rail     (o_pos_rail),
        .o_neg_rail     (o_neg_rail)
    );

endmodule

`default_nettype wire

@@ hw/rtl/hdbn_line_encoder_checker.sv @@
// hdbn_line_encoder_checker: port-level assertions for the HDBn line encoder,
// bound to the top level. Depends on hdbn_pkg and hdbn_line_encoder.
`default_nettype none

module hdbn_line_encoder_checker
    import hdbn_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_in_valid,
    input wire logic    o_in_stall,
    input wire logic    o_out_valid,
    input wire logic    i_out_stall,
    input wire t_symbol o_line_symbol,
    input wire logic    o_pos_rail,
    input wire logic    o_neg_rail,
    input wire logic    psel,
    input wire logic    penable,
    input wire logic    pready
);

    // A held result keeps its symbol
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_line_symbol)))
        else $error("held result changed");

    // Input is stalled only by a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // An accepted request always leaves a result in the output register
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted request produced no result");

    // Rails agree with the signed symbol and never both fire
    a_rails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_pos_rail == (o_line_symbol == SYM_POS))
                         && (o_neg_rail == (o_line_symbol == SYM_NEG))
                         && (o_line_symbol != 2'sb10)))
        else $error("rails disagree with line symbol");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable) |-> pready)
        else $error("pready low during access");

endmodule

bind hdbn_line_encoder hdbn_line_encoder_checker u_checker (.*);

`default_nettype wire

@@ tb/hdbn_enc_checker.sv @@
// Checker for the HDBn line encoder: follows data requests, config writes and results,
// keeps its own encoder state and compares every result in order.
// Depends on hdbn_pkg for the symbol type and register constants.
`default_nettype none

module hdbn_enc_checker
    import hdbn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic              i_data_bit,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire t_symbol           i_line_symbol,
    input  wire logic              i_pos_rail,
    input  wire logic              i_neg_rail,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [APB_AW-1:0] i_paddr,
    input  wire logic [APB_DW-1:0] i_pwdata,
    input  wire logic              i_pready,
    output int                     o_pending,
    output int                     o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_AW-1:0] ORDER_ADDR = APB_AW'(4 * REG_ZERO_RUN_ORDER);
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        t_symbol symbol;
        logic    pos;
        logic    neg;
    } t_line_out;

    t_line_out        line_out_q[$];
    logic [CFG_W-1:0] order_reg;
    t_symbol          tap_line [0:MAX_ORDER];
    int               zero_cnt;
    logic             next_pos;
    logic             last_pos;
    logic             odd_marks;
    int               errors;
    int               results;

    initial begin
        errors    = 0;
        results   = 0;
        o_pending = 0;
        o_errors  = 0;
    end

    function automatic int live_order();
        int n;
        n = int'(order_reg);
        if (n < 1) begin
            n = 1;
        end else if (n > MAX_ORDER) begin
            n = MAX_ORDER;
        end
        return n;
    endfunction

    task automatic clear_encoder();
        order_reg = ORDER_RESET;
        for (int k = 0; k <= MAX_ORDER; k++) begin
            tap_line[k] = SYM_ZERO;
        end
        zero_cnt  = 0;
        next_pos  = 1'b1;
        last_pos  = 1'b1;
        odd_marks = 1'b1;   // first substitution after reset is 000V
    endtask

    // One data bit in, the symbol decided order+1 requests ago out.
    function automatic t_line_out encode_bit(input logic b);
        int        n;
        t_symbol   sym;
        t_symbol   old;
        t_line_out r;
        n   = live_order();
        sym = SYM_ZERO;
        if (b) begin
            sym       = next_pos ? SYM_POS : SYM_NEG;
            last_pos  = next_pos;
            next_pos  = !next_pos;
            odd_marks = !odd_marks;
            zero_cnt  = 0;
        end else if (n > 1) begin
            if (zero_cnt < 255) begin
                zero_cnt++;
            end
            if (zero_cnt >= n + 1) begin
                if (!odd_marks) begin
                    // B00V: balancing pulse goes back onto the first zero of the run
                    last_pos        = !last_pos;
                    tap_line[n - 1] = last_pos ? SYM_POS : SYM_NEG;
                end
                sym       = last_pos ? SYM_POS : SYM_NEG;
                next_pos  = !last_pos;
                odd_marks = 1'b0;
                zero_cnt  = 0;
            end
        end else begin
            zero_cnt = 0;
        end
        old = tap_line[n];
        for (int k = MAX_ORDER; k > 0; k--) begin
            tap_line[k] = tap_line[k - 1];
        end
        tap_line[0] = sym;
        r.symbol = old;
        r.pos    = (old == SYM_POS);
        r.neg    = (old == SYM_NEG);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_line_out want;
        if (!i_rst_n) begin
            clear_encoder();
            line_out_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (line_out_q.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX) begin
                        $display("hdbn_enc_checker: result %0d arrived with none expected",
                                 results);
                    end
                end else begin
                    want = line_out_q.pop_front();
                    if (want.symbol !== i_line_symbol || want.pos !== i_pos_rail ||
                        want.neg !== i_neg_rail) begin
                        errors++;
                        if (errors <= REPORT_MAX) begin
                            $display({"hdbn_enc_checker: result %0d symbol exp %0d got %0d,",
                                      " pos exp %b got %b, neg exp %b got %b"},
                                     results, want.symbol, i_line_symbol,
                                     want.pos, i_pos_rail, want.neg, i_neg_rail);
                        end
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ORDER_ADDR) begin
                order_reg = i_pwdata[CFG_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                line_out_q.push_back(encode_bit(i_data_bit));
            end
        end
        o_pending <= line_out_q.size();
        o_errors  <= errors;
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Top of the HDBn line encoder testbench: clock, reset, data and config stimulus, verdict.
// Depends on hdbn_pkg, the encoder RTL and hdbn_enc_checker.
`default_nettype none

module tb_top
    import hdbn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1250;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 8;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              i_data_bit  = 1'b0;
    logic              i_out_stall = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    t_symbol           o_line_symbol;
    logic              o_pos_rail;
    logic              o_neg_rail;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int   pending;
    int   errors;
    int   sent        = 0;
    int   quiet_count = 0;
    logic calm        = 1'b0;

    always #1 i_clk = ~i_clk;

    hdbn_line_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_bit    (i_data_bit),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_line_symbol (o_line_symbol),
        .o_pos_rail    (o_pos_rail),
        .o_neg_rail    (o_neg_rail),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    hdbn_enc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_data_bit    (i_data_bit),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_line_symbol (o_line_symbol),
        .i_pos_rail    (o_pos_rail),
        .i_neg_rail    (o_neg_rail),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    // Result side backpressure
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog: too long without any request, result or register access
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            psel) begin
            quiet_count <= 0;
        end else if (quiet_count + 1 >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    task automatic send_bit(input logic b);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_bit <= b;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    // A run of zeros, optionally closed by a mark
    task automatic send_run(input int zeros, input logic mark);
        for (int k = 0; k < zeros; k++) begin
            send_bit(1'b0);
        end
        if (mark) begin
            send_bit(1'b1);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_order(input logic [CFG_W-1:0] v);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_AW'(4 * REG_ZERO_RUN_ORDER);
        pwdata  <= APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] ord;
        int               taps;
        int               phase;
        int               stop_at;
        int               burst;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default order 3: first substitution is 000V, then 000V after an odd
        // mark count, then B00V after an even count
        send_run(4, 1'b0);
        send_run(0, 1'b1);
        send_run(4, 1'b0);
        send_run(0, 1'b1);
        send_run(0, 1'b1);
        send_run(4, 1'b0);
        // Leave a zero count behind, then shrink the order under it
        write_order(3'd7);
        send_run(5, 1'b0);
        write_order(3'd2);
        send_run(1, 1'b1);
        // Order zero behaves as plain AMI
        write_order(3'd0);
        send_run(2, 1'b1);

        phase = 0;
        while (sent < ITEM_TARGET) begin
            ord = (phase < 8) ? CFG_W'(phase) : CFG_W'($urandom_range(0, 7));
            taps = (ord == 0) ? 1 : int'(ord);
            write_order(ord);
            calm    <= (phase == 4);
            stop_at = sent + $urandom_range(60, 160);
            while (sent < stop_at) begin
                case ($urandom_range(9))
                    0: begin
                        send_bit(1'($urandom_range(1)));
                    end
                    1, 2: begin
                        burst = $urandom_range(1, 4);
                        repeat (burst) send_bit(1'b1);
                    end
                    default: begin
                        send_run($urandom_range(0, 2 * taps + 3), 1'b1);
                    end
                endcase
            end
            phase++;
        end
        calm <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
